>>> design/kbt_pkg.sv
// ----------------------------------------------------------------------------
// kbt_pkg - shared types and constants for the keyboard report key tracker
// Operation and status codes, usage ranges and the request/result records.
// ----------------------------------------------------------------------------
package kbt_pkg;

  // Report always carries six key slots
  localparam int unsigned ReportSlots = 6;

  // Usage ranges
  localparam logic [7:0] UsageKeyLo = 8'h04;
  localparam logic [7:0] UsageKeyHi = 8'h73;
  localparam logic [7:0] UsageModLo = 8'hE0;
  localparam logic [7:0] UsageModHi = 8'hE7;

  typedef enum logic [2:0] {
    OP_KEY_DOWN    = 3'd0,
    OP_KEY_UP      = 3'd1,
    OP_RELEASE_ALL = 3'd2,
    OP_XPORT_FAIL  = 3'd3,
    OP_DISCONNECT  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_USAGE = 2'd1,
    ST_LINK_DOWN = 2'd2,
    ST_NO_SLOT   = 2'd3
  } status_e;

  // One input request
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] usage_code;
    logic       link_ready;
  } req_t;

  // One result
  typedef struct packed {
    status_e                          status;
    logic                             report_valid;
    logic [7:0]                       modifier_byte;
    logic [ReportSlots-1:0][7:0]      key_slots;
  } result_t;

endpackage

>>> design/kbt_in_reg.sv
// ----------------------------------------------------------------------------
// kbt_in_reg - input request register
// Captures one request; refills in the same cycle the held one moves on.
// ----------------------------------------------------------------------------
module kbt_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  kbt_pkg::req_t  req_i,
  input  logic           advance_i,
  output logic           valid_o,
  output kbt_pkg::req_t  req_o
);

  logic          valid_q;
  kbt_pkg::req_t req_q;

  // Free when empty or when the held request is consumed this cycle
  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign req_o   = req_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      req_q <= req_i;
    end
  end

endmodule

>>> design/kbt_update.sv
// ----------------------------------------------------------------------------
// kbt_update - key state and per-request update logic
// Holds modifier mask and key slots; computes next state and the result.
// ----------------------------------------------------------------------------
module kbt_update #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  kbt_pkg::req_t     req_i,
  output kbt_pkg::result_t  result_o
);

  logic [7:0]                 mod_q, mod_d;
  logic [KEY_SLOTS-1:0][7:0]  keys_q, keys_d;

  logic                 is_mod, is_key, valid_usage;
  logic [7:0]           mod_bit;
  logic [KEY_SLOTS-1:0] match, free, first_free;
  logic                 present;
  kbt_pkg::op_e         op;
  kbt_pkg::status_e     status;
  logic                 rep;

  // Usage decode
  assign is_mod  = (req_i.usage_code >= kbt_pkg::UsageModLo) &&
                   (req_i.usage_code <= kbt_pkg::UsageModHi);
  assign is_key  = (req_i.usage_code >= kbt_pkg::UsageKeyLo) &&
                   (req_i.usage_code <= kbt_pkg::UsageKeyHi);
  assign valid_usage = is_mod || is_key;
  assign mod_bit = 8'd1 << req_i.usage_code[2:0];
  assign op      = kbt_pkg::op_e'(req_i.operation);

  // Parallel slot compares and first-free pick
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      match[i] = (keys_q[i] == req_i.usage_code);
      free[i]  = (keys_q[i] == 8'd0);
    end
  end
  assign present    = |match;
  assign first_free = free & (~free + {{(KEY_SLOTS-1){1'b0}}, 1'b1});

  // Next state and status
  always_comb begin
    mod_d  = mod_q;
    keys_d = keys_q;
    status = kbt_pkg::ST_OK;
    rep    = 1'b0;
    case (op)
      kbt_pkg::OP_KEY_DOWN: begin
        if (!valid_usage) begin
          status = kbt_pkg::ST_BAD_USAGE;
        end else if (!req_i.link_ready) begin
          status = kbt_pkg::ST_LINK_DOWN;
        end else if (is_mod) begin
          mod_d = mod_q | mod_bit;
          rep   = 1'b1;
        end else if (present) begin
          rep = 1'b1;
        end else if (|free) begin
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (first_free[i]) keys_d[i] = req_i.usage_code;
          end
          rep = 1'b1;
        end else begin
          status = kbt_pkg::ST_NO_SLOT;
        end
      end
      kbt_pkg::OP_KEY_UP: begin
        if (!valid_usage) begin
          status = kbt_pkg::ST_BAD_USAGE;
        end else if (!req_i.link_ready) begin
          status = kbt_pkg::ST_LINK_DOWN;
        end else begin
          if (is_mod) begin
            mod_d = mod_q & ~mod_bit;
          end else begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
              if (match[i]) keys_d[i] = 8'd0;
            end
          end
          rep = 1'b1;
        end
      end
      kbt_pkg::OP_RELEASE_ALL: begin
        mod_d  = '0;
        keys_d = '0;
        rep    = req_i.link_ready;
      end
      kbt_pkg::OP_XPORT_FAIL: begin
        if (!req_i.link_ready) begin
          status = kbt_pkg::ST_LINK_DOWN;
        end else begin
          mod_d  = '0;
          keys_d = '0;
          rep    = 1'b1;
        end
      end
      kbt_pkg::OP_DISCONNECT: begin
        mod_d  = '0;
        keys_d = '0;
      end
      default: begin
        status = kbt_pkg::ST_OK;
      end
    endcase
  end

  // Result: report reflects the updated state, zeros when not sent
  assign result_o.status        = status;
  assign result_o.report_valid  = rep;
  assign result_o.modifier_byte = rep ? mod_d : 8'd0;

  for (genvar j = 0; j < kbt_pkg::ReportSlots; j++) begin : g_slot
    if (j < KEY_SLOTS) begin : g_held
      assign result_o.key_slots[j] = rep ? keys_d[j] : 8'd0;
    end else begin : g_empty
      assign result_o.key_slots[j] = 8'd0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= '0;
      keys_q <= '0;
    end else if (advance_i) begin
      mod_q  <= mod_d;
      keys_q <= keys_d;
    end
  end

endmodule

>>> design/kbt_out_reg.sv
// ----------------------------------------------------------------------------
// kbt_out_reg - result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module kbt_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  kbt_pkg::result_t  result_i,
  input  logic              ready_i,
  output logic              valid_o,
  output kbt_pkg::result_t  result_o
);

  logic             valid_q;
  kbt_pkg::result_t result_q;

  assign valid_o  = valid_q;
  assign result_o = result_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

>>> design/keyboard_report_key_tracker_top.sv
// Path: an accepted request is held in the input reg, then its result is loaded into the result reg.
// Throughput: one request per cycle while the result side is not stalled; the combinational
// slot compare and first-free pick between the two registers allow this rate.
// Reset: asynchronous active low; clears modifier mask, all key slots and
// both register valids.
// ----------------------------------------------------------------------------
// keyboard_report_key_tracker_top - boot keyboard pressed-key tracker
// Tracks modifiers and key slots and emits one status/report per request.
// ----------------------------------------------------------------------------
module keyboard_report_key_tracker_top #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] operation, [10:3] usage_code, [11] link_ready, [15:12] zero
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [2] report_valid, [10:3] modifier_byte,
  // [18:11] key_slot_0 ... [58:51] key_slot_5, [63:59] zero
  output logic [63:0] m_axis_tdata_o
);

  kbt_pkg::req_t    req_in, req_held;
  kbt_pkg::result_t result_d, result_q;
  logic             held_valid, advance;

  assign req_in.operation  = s_axis_tdata_i[2:0];
  assign req_in.usage_code = s_axis_tdata_i[10:3];
  assign req_in.link_ready = s_axis_tdata_i[11];

  // A held request moves on when the result register is free or draining
  assign advance = held_valid && (!m_axis_tvalid_o || m_axis_tready_i);

  kbt_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .req_i     (req_in),
    .advance_i (advance),
    .valid_o   (held_valid),
    .req_o     (req_held)
  );

  kbt_update #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (req_held),
    .result_o  (result_d)
  );

  kbt_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result_d),
    .ready_i  (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .result_o (result_q)
  );

  // Pack result, first field lowest
  assign m_axis_tdata_o = {5'd0, result_q.key_slots, result_q.modifier_byte,
                           result_q.report_valid, result_q.status};

endmodule
